/* design/unsigned_to_decimal_ascii_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for unsigned_to_decimal_ascii
// Shared property forms used by the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udec: next-cycle check failed");

`endif

/* design/udec_pkg.sv */
// ----------------------------------------------------------------------------
// udec_pkg
// Types, constants and helper functions of the decimal ASCII converter.
// ----------------------------------------------------------------------------
package udec_pkg;

   localparam int VALUE_FIELD_W = 64;
   localparam int VALUE_WIDTH   = 64;
   localparam int MAX_DIGITS    = 20;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = MAX_DIGITS * DIGIT_W;
   localparam int BIT_CNT_W     = $clog2(VALUE_WIDTH);
   localparam int DIGIT_CNT_W   = $clog2(MAX_DIGITS);
   localparam int CHAR_W        = 6;
   localparam int RSP_TDATA_W   = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'h30;
   localparam logic [CHAR_W-1:0]  ASCII_NINE   = 6'h39;
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   is_zero;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } back_state_type;

   // Add three to every BCD digit of five or more, ahead of the shift.
   function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] result;
      result = bcd;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
            result[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
         end
      end
      return result;
   endfunction

endpackage

/* design/udec_front.sv */
// ----------------------------------------------------------------------------
// udec_front
// Accepts input transactions, masks the value and marks zero values.
// ----------------------------------------------------------------------------
module udec_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [udec_pkg::VALUE_FIELD_W-1:0]   req_tdata,   // [63:0] value
   output logic                                 push_valid,
   output udec_pkg::item_type                   push_item,
   input  logic                                 push_ready
);

   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   udec_pkg::item_type   hold_item_ff;
   udec_pkg::item_type   hold_item_in;
   logic                 req_accept;

   assign req_tready = !hold_valid_ff || push_ready;
   assign req_accept = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_comb begin
      hold_valid_in = (hold_valid_ff && !push_ready) || req_accept;
      hold_item_in  = hold_item_ff;
      if (req_accept) begin
         hold_item_in.value   = req_tdata[udec_pkg::VALUE_WIDTH-1:0];
         hold_item_in.is_zero = (req_tdata[udec_pkg::VALUE_WIDTH-1:0] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

endmodule

/* design/udec_queue.sv */
// ----------------------------------------------------------------------------
// udec_queue
// Short first-in first-out queue between the front and the converter.
// ----------------------------------------------------------------------------
module udec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  udec_pkg::item_type   push_item,
   output logic                 push_ready,
   output logic                 pop_valid,
   output udec_pkg::item_type   pop_item,
   input  logic                 pop_ready
);

   udec_pkg::item_type                  entry_ff [udec_pkg::QUEUE_DEPTH];
   logic [udec_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [udec_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [udec_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [udec_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [udec_pkg::QCNT_W-1:0]         count_ff;
   logic [udec_pkg::QCNT_W-1:0]         count_in;
   logic                                do_push;
   logic                                do_pop;

   assign push_ready = (count_ff != udec_pkg::QCNT_W'(udec_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == udec_pkg::QPTR_W'(udec_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == udec_pkg::QPTR_W'(udec_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/udec_back.sv */
// ----------------------------------------------------------------------------
// udec_back
// Bit-serial double dabble converter with a digit emitter and output register.
// ----------------------------------------------------------------------------
module udec_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   input  udec_pkg::item_type                   pop_item,
   output logic                                 pop_ready,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [udec_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   udec_pkg::back_state_type               state_ff;
   udec_pkg::back_state_type               state_in;
   logic [udec_pkg::VALUE_WIDTH-1:0]       shift_ff;
   logic [udec_pkg::VALUE_WIDTH-1:0]       shift_in;
   logic [udec_pkg::BCD_W-1:0]             bcd_ff;
   logic [udec_pkg::BCD_W-1:0]             bcd_in;
   logic [udec_pkg::BIT_CNT_W-1:0]         bit_cnt_ff;
   logic [udec_pkg::BIT_CNT_W-1:0]         bit_cnt_in;
   logic [udec_pkg::DIGIT_CNT_W-1:0]       digit_cnt_ff;
   logic [udec_pkg::DIGIT_CNT_W-1:0]       digit_cnt_in;
   logic                                   started_ff;
   logic                                   started_in;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic [udec_pkg::CHAR_W-1:0]            out_char_ff;
   logic [udec_pkg::CHAR_W-1:0]            out_char_in;
   logic                                   out_last_ff;
   logic                                   out_last_in;
   logic                                   out_free;
   logic                                   final_digit;
   logic [udec_pkg::DIGIT_W-1:0]           top_digit;
   logic [udec_pkg::BCD_W-1:0]             adjusted;
   logic [udec_pkg::BCD_W-1:0]             bcd_next_digit;

   assign out_free       = !out_valid_ff || rsp_tready;
   assign top_digit      = bcd_ff[udec_pkg::BCD_W-1 -: udec_pkg::DIGIT_W];
   assign final_digit    = (digit_cnt_ff == '0);
   assign adjusted       = udec_pkg::dabble_adjust(bcd_ff);
   assign bcd_next_digit = {bcd_ff[udec_pkg::BCD_W-udec_pkg::DIGIT_W-1:0],
                            {udec_pkg::DIGIT_W{1'b0}}};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(udec_pkg::RSP_TDATA_W - udec_pkg::CHAR_W){1'b0}}, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      pop_ready    = 1'b0;
      unique case (state_ff)
         udec_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               shift_in     = pop_item.value;
               bcd_in       = '0;
               bit_cnt_in   = '0;
               digit_cnt_in = udec_pkg::DIGIT_CNT_W'(udec_pkg::MAX_DIGITS - 1);
               started_in   = 1'b0;
               // A zero value needs no conversion: the cleared BCD register is the answer.
               state_in     = pop_item.is_zero ? udec_pkg::ST_EMIT : udec_pkg::ST_CONVERT;
            end
         end
         udec_pkg::ST_CONVERT: begin
            bcd_in     = {adjusted[udec_pkg::BCD_W-2:0], shift_ff[udec_pkg::VALUE_WIDTH-1]};
            shift_in   = {shift_ff[udec_pkg::VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == udec_pkg::BIT_CNT_W'(udec_pkg::VALUE_WIDTH - 1)) begin
               state_in = udec_pkg::ST_EMIT;
            end
         end
         udec_pkg::ST_EMIT: begin
            // Leading zeros are dropped, but the units digit is always sent.
            if (!started_ff && (top_digit == '0) && !final_digit) begin
               bcd_in       = bcd_next_digit;
               digit_cnt_in = digit_cnt_ff - 1'b1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = udec_pkg::ASCII_ZERO + udec_pkg::CHAR_W'(top_digit);
               out_last_in  = final_digit;
               started_in   = 1'b1;
               bcd_in       = bcd_next_digit;
               digit_cnt_in = digit_cnt_ff - 1'b1;
               if (final_digit) begin
                  state_in = udec_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = udec_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udec_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
      started_ff   <= started_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

endmodule

/* design/unsigned_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Writes a 64-bit unsigned value as ASCII decimal digits, most significant
// first, without leading zeros.
// ----------------------------------------------------------------------------
// Channel   Direction   Payload
// req_      in          tdata[63:0] value
// rsp_      out         tdata[5:0] digit_char, tdata[7:6] zero; tlast = last
//
// Each value leaves the queue, passes bit by bit through the bit-serial double
// dabble loop, then through the digit emitter, which visits the digit positions
// in turn; a zero value skips the loop.
// A two-entry queue lets the front take new values while the converter works.
// Reset is synchronous and clears the queue, the converter and the output
// register. A stalled result holds the converter in the emitter; the front
// register and the queue still take up to three more values meanwhile.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_macros.svh"

module unsigned_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [udec_pkg::VALUE_FIELD_W-1:0]   req_tdata,   // [63:0] value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [udec_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [5:0] digit_char
   output logic                                 rsp_tlast
);

   logic                 push_valid;
   udec_pkg::item_type   push_item;
   logic                 push_ready;
   logic                 pop_valid;
   udec_pkg::item_type   pop_item;
   logic                 pop_ready;
   logic                 at_start_ff;
   logic                 at_start_in;

   udec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   udec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   udec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Tracks whether the next result transaction opens a new run of digits.
   always_comb begin
      at_start_in = at_start_ff;
      if (rsp_tvalid && rsp_tready) begin
         at_start_in = rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

   `UDEC_ASSERT_IMPLY(a_digit_range, clock, reset, rsp_tvalid,
      (rsp_tdata[5:0] >= udec_pkg::ASCII_ZERO) && (rsp_tdata[5:0] <= udec_pkg::ASCII_NINE)
      && (rsp_tdata[7:6] == 2'b00))
   `UDEC_ASSERT_IMPLY(a_no_leading_zero, clock, reset,
      rsp_tvalid && at_start_ff && (rsp_tdata[5:0] == udec_pkg::ASCII_ZERO), rsp_tlast)
   `UDEC_ASSERT_NEXT(a_front_holds_item, clock, reset, push_valid && !push_ready, push_valid)

endmodule
